>>> sv/qvr_pkg.sv
// Package: widths, rounding constants, register map and product bundles for the rotate unit.
`timescale 1ns / 1ps

package qvr_pkg;

   // Fixed-point format of the quaternion registers
   localparam int FRAC_BITS = 14;

   // Field widths
   localparam int QUAT_W = 16;
   localparam int VEC_W  = 16;
   localparam int ROT_W  = 18;
   localparam int HOM_W  = 16;

   // Configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // First product q * v: raw products, three-term sums with headroom, rounded result
   localparam int P1_W = QUAT_W + VEC_W;
   localparam int S1_W = P1_W + 3;
   localparam int T_W  = S1_W - FRAC_BITS;

   // Second product t * conj(q): raw products, four-term sums with headroom
   localparam int P2_W = T_W + QUAT_W;
   localparam int S2_W = P2_W + 3;

   // Round-to-nearest bias, ties toward plus infinity
   localparam logic signed [S1_W-1:0] RND1 = S1_W'(64'd1 << (FRAC_BITS - 1));
   localparam logic signed [S2_W-1:0] RND2 = S2_W'(64'd1 << (FRAC_BITS - 1));

   // Saturation bounds of the rotated coordinates
   localparam logic signed [S2_W-1:0] ROT_MAX = S2_W'((64'sd1 <<< (ROT_W - 1)) - 64'sd1);
   localparam logic signed [S2_W-1:0] ROT_MIN = S2_W'(-(64'sd1 <<< (ROT_W - 1)));

   // Register map, one word each
   typedef enum logic [1:0] {
      REG_QUAT_I    = 2'd0,
      REG_QUAT_J    = 2'd1,
      REG_QUAT_K    = 2'd2,
      REG_QUAT_REAL = 2'd3
   } qvr_reg_type;

   localparam logic signed [QUAT_W-1:0] QUAT_REAL_RESET = QUAT_W'(64'd1 << FRAC_BITS);

   // Products of q and v: first letter from q, second from v (w is the scalar)
   typedef struct packed {
      logic signed [P1_W-1:0] wx, yz, zy;
      logic signed [P1_W-1:0] wy, xz, zx;
      logic signed [P1_W-1:0] wz, xy, yx;
      logic signed [P1_W-1:0] xx, yy, zz;
   } prod1_type;

   // Products of t and q: first letter from t, second from q
   typedef struct packed {
      logic signed [P2_W-1:0] wx, xw, yz, zy;
      logic signed [P2_W-1:0] wy, xz, yw, zx;
      logic signed [P2_W-1:0] wz, xy, yx, zw;
   } prod2_type;

endpackage

>>> sv/qvr_req_if.sv
// Interface: input vector channel with valid/ready handshake.
`timescale 1ns / 1ps

interface qvr_req_if import qvr_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic signed [VEC_W-1:0] vec_x;
   logic signed [VEC_W-1:0] vec_y;
   logic signed [VEC_W-1:0] vec_z;
   logic signed [HOM_W-1:0] vec_h;

   modport source (output valid, output vec_x, output vec_y, output vec_z, output vec_h,
                   input ready);
   modport sink   (input valid, input vec_x, input vec_y, input vec_z, input vec_h,
                   output ready);
endinterface

>>> sv/qvr_rsp_if.sv
// Interface: rotated vector channel with valid/ready handshake.
`timescale 1ns / 1ps

interface qvr_rsp_if import qvr_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic signed [ROT_W-1:0] rot_x;
   logic signed [ROT_W-1:0] rot_y;
   logic signed [ROT_W-1:0] rot_z;
   logic signed [HOM_W-1:0] rot_h;

   modport source (output valid, output rot_x, output rot_y, output rot_z, output rot_h,
                   input ready);
   modport sink   (input valid, input rot_x, input rot_y, input rot_z, input rot_h,
                   output ready);
endinterface

>>> sv/quaternion_vector_rotate_unit.sv
// Top level: five-stage pipeline rotating vectors by q * v * conj(q), with APB register port.
//
//   channel   direction  handshake              beat contents
//   req_if    in         valid/ready            vec_x, vec_y, vec_z, vec_h
//   rsp_if    out        valid/ready            rot_x, rot_y, rot_z, rot_h
//   csr_*     in         APB setup + access     quaternion i, j, k, real (Q2.14)
//
// One beat enters per clock while req_if.ready is high; results leave the output register.
// Stages: q*v products, round t, t*conj(q) products, round r, saturate into the output register.
// Each stage holds only while it is full and the stage after it holds, so bubbles close up
// and req_if.ready falls only when all five stages are full and the output is not taken.
// Synchronous reset empties the pipeline and loads the identity rotation.
`timescale 1ns / 1ps

module quaternion_vector_rotate_unit import qvr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   qvr_req_if.sink               req_if,
   qvr_rsp_if.source             rsp_if,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // ---------------------------------------------------------------
   // Quaternion registers
   // ---------------------------------------------------------------
   logic signed [QUAT_W-1:0] quat_i_ff, quat_j_ff, quat_k_ff, quat_real_ff;
   logic signed [QUAT_W-1:0] quat_i_in, quat_j_in, quat_k_in, quat_real_in;
   logic                     csr_write;
   qvr_reg_type              csr_reg;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_reg    = qvr_reg_type'(csr_paddr[3:2]);

   // Decode the write beat
   always_comb begin
      quat_i_in    = quat_i_ff;
      quat_j_in    = quat_j_ff;
      quat_k_in    = quat_k_ff;
      quat_real_in = quat_real_ff;
      if (csr_write) begin
         case (csr_reg)
            REG_QUAT_I:    quat_i_in    = csr_pwdata[QUAT_W-1:0];
            REG_QUAT_J:    quat_j_in    = csr_pwdata[QUAT_W-1:0];
            REG_QUAT_K:    quat_k_in    = csr_pwdata[QUAT_W-1:0];
            REG_QUAT_REAL: quat_real_in = csr_pwdata[QUAT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quat_i_ff    <= '0;
         quat_j_ff    <= '0;
         quat_k_ff    <= '0;
         quat_real_ff <= QUAT_REAL_RESET;
      end else begin
         quat_i_ff    <= quat_i_in;
         quat_j_ff    <= quat_j_in;
         quat_k_ff    <= quat_k_in;
         quat_real_ff <= quat_real_in;
      end
   end

   // Read back the addressed register
   always_comb begin
      case (csr_reg)
         REG_QUAT_I:    csr_prdata = {{(CSR_DATA_W-QUAT_W){1'b0}}, quat_i_ff};
         REG_QUAT_J:    csr_prdata = {{(CSR_DATA_W-QUAT_W){1'b0}}, quat_j_ff};
         REG_QUAT_K:    csr_prdata = {{(CSR_DATA_W-QUAT_W){1'b0}}, quat_k_ff};
         REG_QUAT_REAL: csr_prdata = {{(CSR_DATA_W-QUAT_W){1'b0}}, quat_real_ff};
         default:       csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------
   // Pipeline flow control: a stage advances when empty or when the next advances
   // ---------------------------------------------------------------
   logic valid1_ff, valid2_ff, valid3_ff, valid4_ff, valid5_ff;
   logic adv1, adv2, adv3, adv4, adv5;

   assign adv5 = !valid5_ff || rsp_if.ready;
   assign adv4 = !valid4_ff || adv5;
   assign adv3 = !valid3_ff || adv4;
   assign adv2 = !valid2_ff || adv3;
   assign adv1 = !valid1_ff || adv2;

   assign req_if.ready = adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
         valid5_ff <= 1'b0;
      end else begin
         if (adv1) valid1_ff <= req_if.valid;
         if (adv2) valid2_ff <= valid1_ff;
         if (adv3) valid3_ff <= valid2_ff;
         if (adv4) valid4_ff <= valid3_ff;
         if (adv5) valid5_ff <= valid4_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: products of q and the pure vector quaternion
   // ---------------------------------------------------------------
   prod1_type               prod1_in, prod1_ff;
   logic signed [HOM_W-1:0] hom1_ff, hom2_ff, hom3_ff, hom4_ff, hom5_ff;

   always_comb begin
      prod1_in.wx = quat_real_ff * req_if.vec_x;
      prod1_in.yz = quat_j_ff    * req_if.vec_z;
      prod1_in.zy = quat_k_ff    * req_if.vec_y;
      prod1_in.wy = quat_real_ff * req_if.vec_y;
      prod1_in.xz = quat_i_ff    * req_if.vec_z;
      prod1_in.zx = quat_k_ff    * req_if.vec_x;
      prod1_in.wz = quat_real_ff * req_if.vec_z;
      prod1_in.xy = quat_i_ff    * req_if.vec_y;
      prod1_in.yx = quat_j_ff    * req_if.vec_x;
      prod1_in.xx = quat_i_ff    * req_if.vec_x;
      prod1_in.yy = quat_j_ff    * req_if.vec_y;
      prod1_in.zz = quat_k_ff    * req_if.vec_z;
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         prod1_ff <= prod1_in;
         hom1_ff  <= req_if.vec_h;
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: sum and round t = q * v
   // ---------------------------------------------------------------
   logic signed [T_W-1:0] tx_in, ty_in, tz_in, tw_in;
   logic signed [T_W-1:0] tx_ff, ty_ff, tz_ff, tw_ff;

   always_comb begin
      tx_in = T_W'((S1_W'(prod1_ff.wx) + S1_W'(prod1_ff.yz) - S1_W'(prod1_ff.zy) + RND1)
                   >>> FRAC_BITS);
      ty_in = T_W'((S1_W'(prod1_ff.wy) - S1_W'(prod1_ff.xz) + S1_W'(prod1_ff.zx) + RND1)
                   >>> FRAC_BITS);
      tz_in = T_W'((S1_W'(prod1_ff.wz) + S1_W'(prod1_ff.xy) - S1_W'(prod1_ff.yx) + RND1)
                   >>> FRAC_BITS);
      tw_in = T_W'((RND1 - S1_W'(prod1_ff.xx) - S1_W'(prod1_ff.yy) - S1_W'(prod1_ff.zz))
                   >>> FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         tx_ff   <= tx_in;
         ty_ff   <= ty_in;
         tz_ff   <= tz_in;
         tw_ff   <= tw_in;
         hom2_ff <= hom1_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: products of t and q
   // ---------------------------------------------------------------
   prod2_type prod2_in, prod2_ff;

   always_comb begin
      prod2_in.wx = tw_ff * quat_i_ff;
      prod2_in.xw = tx_ff * quat_real_ff;
      prod2_in.yz = ty_ff * quat_k_ff;
      prod2_in.zy = tz_ff * quat_j_ff;
      prod2_in.wy = tw_ff * quat_j_ff;
      prod2_in.xz = tx_ff * quat_k_ff;
      prod2_in.yw = ty_ff * quat_real_ff;
      prod2_in.zx = tz_ff * quat_i_ff;
      prod2_in.wz = tw_ff * quat_k_ff;
      prod2_in.xy = tx_ff * quat_j_ff;
      prod2_in.yx = ty_ff * quat_i_ff;
      prod2_in.zw = tz_ff * quat_real_ff;
   end

   always_ff @(posedge clock) begin
      if (adv3) begin
         prod2_ff <= prod2_in;
         hom3_ff  <= hom2_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 4: sum and round the vector part of t * conj(q)
   // ---------------------------------------------------------------
   logic signed [S2_W-1:0] rx_in, ry_in, rz_in;
   logic signed [S2_W-1:0] rx_ff, ry_ff, rz_ff;

   always_comb begin
      rx_in = (S2_W'(prod2_ff.xw) - S2_W'(prod2_ff.wx) - S2_W'(prod2_ff.yz)
               + S2_W'(prod2_ff.zy) + RND2) >>> FRAC_BITS;
      ry_in = (S2_W'(prod2_ff.xz) - S2_W'(prod2_ff.wy) + S2_W'(prod2_ff.yw)
               - S2_W'(prod2_ff.zx) + RND2) >>> FRAC_BITS;
      rz_in = (S2_W'(prod2_ff.yx) - S2_W'(prod2_ff.wz) - S2_W'(prod2_ff.xy)
               + S2_W'(prod2_ff.zw) + RND2) >>> FRAC_BITS;
   end

   always_ff @(posedge clock) begin
      if (adv4) begin
         rx_ff   <= rx_in;
         ry_ff   <= ry_in;
         rz_ff   <= rz_in;
         hom4_ff <= hom3_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 5: saturate into the output register
   // ---------------------------------------------------------------
   logic signed [ROT_W-1:0] rot_x_in, rot_y_in, rot_z_in;
   logic signed [ROT_W-1:0] rot_x_ff, rot_y_ff, rot_z_ff;

   always_comb begin
      if (rx_ff > ROT_MAX)      rot_x_in = ROT_MAX[ROT_W-1:0];
      else if (rx_ff < ROT_MIN) rot_x_in = ROT_MIN[ROT_W-1:0];
      else                      rot_x_in = rx_ff[ROT_W-1:0];

      if (ry_ff > ROT_MAX)      rot_y_in = ROT_MAX[ROT_W-1:0];
      else if (ry_ff < ROT_MIN) rot_y_in = ROT_MIN[ROT_W-1:0];
      else                      rot_y_in = ry_ff[ROT_W-1:0];

      if (rz_ff > ROT_MAX)      rot_z_in = ROT_MAX[ROT_W-1:0];
      else if (rz_ff < ROT_MIN) rot_z_in = ROT_MIN[ROT_W-1:0];
      else                      rot_z_in = rz_ff[ROT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv5) begin
         rot_x_ff <= rot_x_in;
         rot_y_ff <= rot_y_in;
         rot_z_ff <= rot_z_in;
         hom5_ff  <= hom4_ff;
      end
   end

   // Drive the result beat
   assign rsp_if.valid = valid5_ff;
   assign rsp_if.rot_x = rot_x_ff;
   assign rsp_if.rot_y = rot_y_ff;
   assign rsp_if.rot_z = rot_z_ff;
   assign rsp_if.rot_h = hom5_ff;

endmodule
